@@ sv/kse_pkg.sv @@
// Package with the shared types and codes of the keypad scan event detector.
package kse_pkg;

	typedef logic [4:0] key_t;
	typedef logic [1:0] event_code_t;
	typedef logic [1:0] layout_t;

	localparam key_t NO_KEY = 5'd16;

	localparam event_code_t EV_NONE    = 2'd0;
	localparam event_code_t EV_PRESS   = 2'd1;
	localparam event_code_t EV_RELEASE = 2'd2;
	localparam event_code_t EV_HOLD    = 2'd3;

	localparam layout_t LAYOUT_1X4 = 2'd0;
	localparam layout_t LAYOUT_4X3 = 2'd1;
	localparam layout_t LAYOUT_4X4 = 2'd2;

	localparam logic REG_KEYPAD_TYPE  = 1'b0;
	localparam logic REG_HOLD_TIME_MS = 1'b1;

	localparam layout_t     KEYPAD_TYPE_RESET = LAYOUT_4X4;
	localparam logic [31:0] HOLD_TIME_RESET   = 32'd1000;

	typedef struct packed {
		event_code_t key_event;
		logic [3:0]  key_index;
	} event_result_t;

endpackage

@@ sv/keypad_scan_event_detector.sv @@
// Top level of the keypad scan event detector: scan input stage, configuration and event output.
//
// A scan beat carries sensed_keys (one bit per contact, drive line times four plus sense line)
// and now_ms, a free-running millisecond time. It is taken when scan_valid is high and
// scan_stall is low. Every scan gives exactly one event beat on key_event and key_index,
// taken when event_valid is high and event_stall is low.
// The scan is registered on entry, the event is decided against the stored key state and
// registered on exit, so each scan passes the input register and then the event register.
// One scan is taken every cycle while scan_stall is low; the stored key state is updated in
// the same cycle the event register loads, which is the only loop in the block.
// When the receiver stalls, the event register holds its beat and the input register keeps
// one more scan; scan_stall rises only once both are full.
// Configuration writes (index 0 keypad_type, index 1 hold_time_ms) are taken at any cycle
// with cfg_valid high, but are meant to be issued while no scan is in flight.
// Reset clears both stages, forgets any pressed or armed key, sets the press time to zero,
// keypad_type to the four by four layout and hold_time_ms to 1000.
module keypad_scan_event_detector (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      scan_valid,
	output logic                      scan_stall,
	input  logic [15:0]               sensed_keys,
	input  logic [31:0]               now_ms,
	output logic                      event_valid,
	input  logic                      event_stall,
	output kse_pkg::event_code_t      key_event,
	output logic [3:0]                key_index,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [31:0]               cfg_data
);
	import kse_pkg::*;

	layout_t       keypad_type_q;
	logic [31:0]   hold_time_ms_q;

	logic          valid_s1;
	logic [15:0]   sensed_keys_s1;
	logic [31:0]   now_ms_s1;

	logic          event_valid_q;
	event_result_t event_q;

	logic          advance;
	key_t          key;
	event_result_t result;

	assign cfg_ready   = 1'b1;
	assign advance     = valid_s1 && (!event_valid_q || !event_stall);
	assign scan_stall  = valid_s1 && !advance;
	assign event_valid = event_valid_q;
	assign key_event   = event_q.key_event;
	assign key_index   = event_q.key_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keypad_type_q  <= KEYPAD_TYPE_RESET;
			hold_time_ms_q <= HOLD_TIME_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEYPAD_TYPE: begin
					keypad_type_q <= cfg_data[1:0];
				end
				REG_HOLD_TIME_MS: begin
					hold_time_ms_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!scan_stall) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_valid && !scan_stall) begin
			sensed_keys_s1 <= sensed_keys;
			now_ms_s1      <= now_ms;
		end
	end

	kse_key_pick u_key_pick (
		.sensed_keys (sensed_keys_s1),
		.keypad_type (keypad_type_q),
		.key         (key)
	);

	kse_event u_event (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.key          (key),
		.now_ms       (now_ms_s1),
		.hold_time_ms (hold_time_ms_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid_q <= 1'b0;
		end else if (advance) begin
			event_valid_q <= 1'b1;
		end else if (!event_stall) begin
			event_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_none_has_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid_q && (event_q.key_event == EV_NONE) |-> (event_q.key_index == 4'd0))
		else $error("An empty event carries a non-zero key index.");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stall |-> (valid_s1 && event_valid_q && event_stall))
		else $error("Scan input stalled while a stage was free.");

	a_advance_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> event_valid_q)
		else $error("An advanced scan did not reach the event register.");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		scan_valid && !scan_stall |=> valid_s1)
		else $error("An accepted scan beat was lost at the input stage.");
`endif

endmodule

@@ sv/kse_key_pick.sv @@
// Priority encoder that reduces a contact bitmap to one active key for the chosen layout.
module kse_key_pick (
	input  logic [15:0]       sensed_keys,
	input  kse_pkg::layout_t  keypad_type,
	output kse_pkg::key_t     key
);
	import kse_pkg::*;

	always_comb begin
		key = NO_KEY;
		case (keypad_type)
			LAYOUT_1X4: begin
				if (sensed_keys[3]) begin
					key = 5'd2;
				end else if (sensed_keys[2]) begin
					key = 5'd3;
				end else if (sensed_keys[1]) begin
					key = 5'd0;
				end else if (sensed_keys[0]) begin
					key = 5'd1;
				end
			end
			LAYOUT_4X3: begin
				for (int b = 0; b < 16; b++) begin
					if ((b % 4) != 3 && sensed_keys[b]) begin
						key = 5'((b / 4) * 3 + (b % 4));
					end
				end
			end
			LAYOUT_4X4: begin
				for (int b = 0; b < 16; b++) begin
					if (sensed_keys[b]) begin
						key = 5'(b);
					end
				end
			end
			default: begin
				key = NO_KEY;
			end
		endcase
	end

endmodule

@@ sv/kse_event.sv @@
// Event decision logic with the previous key, armed key and press time registers.
module kse_event (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  kse_pkg::key_t          key,
	input  logic [31:0]            now_ms,
	input  logic [31:0]            hold_time_ms,
	output kse_pkg::event_result_t result
);
	import kse_pkg::*;

	key_t        previous_key_q;
	key_t        armed_key_q;
	logic [31:0] press_time_q;

	logic        key_down;
	logic        is_press;
	logic        is_release;
	logic        is_hold;
	key_t        armed_next;
	logic [31:0] press_time_next;
	logic [31:0] elapsed;

	always_comb begin
		key_down        = (key != NO_KEY);
		is_press        = key_down && (key != previous_key_q);
		is_release      = !key_down && (previous_key_q != NO_KEY) && (armed_key_q != NO_KEY);
		armed_next      = is_press ? key : armed_key_q;
		press_time_next = is_press ? now_ms : press_time_q;
		elapsed         = now_ms - press_time_next;
		is_hold         = key_down && (armed_next != NO_KEY) && (elapsed > hold_time_ms);

		if (is_hold) begin
			result.key_event = EV_HOLD;
			result.key_index = key[3:0];
		end else if (is_press) begin
			result.key_event = EV_PRESS;
			result.key_index = key[3:0];
		end else if (is_release) begin
			result.key_event = EV_RELEASE;
			result.key_index = previous_key_q[3:0];
		end else begin
			result.key_event = EV_NONE;
			result.key_index = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_key_q <= NO_KEY;
			armed_key_q    <= NO_KEY;
			press_time_q   <= 32'd0;
		end else if (advance) begin
			previous_key_q <= key;
			armed_key_q    <= is_hold ? NO_KEY : armed_next;
			press_time_q   <= is_hold ? now_ms : press_time_next;
		end
	end

endmodule

@@ bench/kse_event_checker.sv @@
// Checker that predicts the event beat of every scan beat and compares it with the block's output.
module kse_event_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 scan_valid,
	input  logic                 scan_stall,
	input  logic [15:0]          sensed_keys,
	input  logic [31:0]          now_ms,
	input  logic                 event_valid,
	input  logic                 event_stall,
	input  kse_pkg::event_code_t key_event,
	input  logic [3:0]           key_index,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   fail_count,
	output int                   outstanding
);
	import kse_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	layout_t         layout_cfg;
	logic [31:0]     hold_cfg;
	key_t            last_key;
	key_t            armed;
	logic [31:0]     pressed_at;
	event_result_t   pending_events [$];
	int              errors;

	function automatic key_t select_key(input logic [15:0] contacts, input layout_t layout);
		key_t k;
		int b;
		k = NO_KEY;
		if (layout == LAYOUT_1X4) begin
			if (contacts[0]) k = 5'd1;
			if (contacts[1]) k = 5'd0;
			if (contacts[2]) k = 5'd3;
			if (contacts[3]) k = 5'd2;
		end else if (layout == LAYOUT_4X3) begin
			for (b = 0; b < 16; b++)
				if ((b % 4) != 3 && contacts[b]) k = key_t'((b / 4) * 3 + (b % 4));
		end else if (layout == LAYOUT_4X4) begin
			for (b = 0; b < 16; b++)
				if (contacts[b]) k = key_t'(b);
		end
		return k;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		event_result_t want;
		key_t k;
		logic [31:0] elapsed;
		if (!arst_n) begin
			layout_cfg = KEYPAD_TYPE_RESET;
			hold_cfg = HOLD_TIME_RESET;
			last_key = NO_KEY;
			armed = NO_KEY;
			pressed_at = '0;
			pending_events.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (event_valid && !event_stall) begin
				if (pending_events.size() == 0) begin
					$error("event beat with nothing expected: key_event %0d key_index %0d",
						key_event, key_index);
					errors++;
				end else begin
					want = pending_events.pop_front();
					if (key_event !== want.key_event) begin
						$error("key_event: expected %0d, got %0d", want.key_event, key_event);
						errors++;
					end
					if (key_index !== want.key_index) begin
						$error("key_index: expected %0d, got %0d", want.key_index, key_index);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEYPAD_TYPE: begin
						layout_cfg = cfg_data[1:0];
					end
					REG_HOLD_TIME_MS: begin
						hold_cfg = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (scan_valid && !scan_stall) begin
				k = select_key(sensed_keys, layout_cfg);
				want.key_event = EV_NONE;
				want.key_index = '0;
				if (k != NO_KEY && k != last_key) begin
					armed = k;
					pressed_at = now_ms;
					want.key_event = EV_PRESS;
					want.key_index = k[3:0];
				end
				if (k == NO_KEY && last_key != NO_KEY && armed != NO_KEY) begin
					want.key_event = EV_RELEASE;
					want.key_index = last_key[3:0];
				end
				elapsed = now_ms - pressed_at;
				if (k != NO_KEY && armed != NO_KEY && elapsed > hold_cfg) begin
					armed = NO_KEY;
					pressed_at = now_ms;
					want.key_event = EV_HOLD;
					want.key_index = k[3:0];
				end
				last_key = k;
				pending_events.push_back(want);
			end
			fail_count <= errors;
			outstanding <= pending_events.size();
		end
	end

endmodule

@@ bench/tb_keypad_scan_event_detector.sv @@
// Top of the keypad scan event detector testbench: clock, reset, scan and register stimulus, verdict.
module tb_keypad_scan_event_detector;
	import kse_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam layout_t LAYOUT_UNUSED = 2'd3;
	localparam int      CYCLE_LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        scan_valid = 1'b0;
	logic        scan_stall;
	logic [15:0] sensed_keys = '0;
	logic [31:0] now_ms = '0;
	logic        event_valid;
	logic        event_stall = 1'b0;
	event_code_t key_event;
	logic [3:0]  key_index;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_KEYPAD_TYPE;
	logic [31:0] cfg_data = '0;

	int          fail_count;
	int          outstanding;
	int          scans_sent = 0;
	int          reg_writes = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          cycles = 0;
	logic [31:0] hold_now = HOLD_TIME_RESET;

	keypad_scan_event_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan_valid  (scan_valid),
		.scan_stall  (scan_stall),
		.sensed_keys (sensed_keys),
		.now_ms      (now_ms),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.key_event   (key_event),
		.key_index   (key_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	kse_event_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan_valid  (scan_valid),
		.scan_stall  (scan_stall),
		.sensed_keys (sensed_keys),
		.now_ms      (now_ms),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.key_event   (key_event),
		.key_index   (key_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		event_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_scan(input logic [15:0] contacts, input logic [31:0] stamp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			scan_valid <= 1'b0;
			@(posedge clk);
		end
		scan_valid <= 1'b1;
		sensed_keys <= contacts;
		now_ms <= stamp;
		do @(posedge clk); while (scan_stall);
		scans_sent++;
	endtask

	task automatic drain();
		scan_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == REG_HOLD_TIME_MS) hold_now = data;
	endtask

	function automatic logic [15:0] pick_contacts();
		logic [15:0] c;
		case ($urandom_range(0, 3))
			0: c = 16'h0001 << $urandom_range(0, 15);
			1: c = 16'($urandom) & 16'($urandom);
			2: c = 16'($urandom);
			default: c = 16'h000F & 16'($urandom);
		endcase
		return c;
	endfunction

	task automatic play_random(input int count);
		int stop;
		int span;
		logic [15:0] contacts;
		logic [31:0] stamp;
		stop = scans_sent + count;
		stamp = $urandom;
		span = (hold_now < 40) ? int'(hold_now) * 2 + 3 : 40;
		while (scans_sent < stop) begin
			if ($urandom_range(0, 9) < 7) begin
				contacts = pick_contacts();
				repeat ($urandom_range(1, 12)) begin
					if ($urandom_range(0, 7) == 0) contacts = pick_contacts();
					send_scan(contacts, stamp);
					stamp += $urandom_range(0, span);
					if ($urandom_range(0, 15) == 0) stamp += $urandom;
				end
				repeat ($urandom_range(1, 3)) begin
					send_scan(16'h0000, stamp);
					stamp += $urandom_range(0, span);
				end
			end else begin
				send_scan(16'($urandom), ($urandom_range(0, 1) == 0) ? stamp : $urandom);
			end
		end
	endtask

	initial begin
		layout_t     layout_plan [11];
		logic [31:0] hold_plan [11];
		logic [31:0] t;
		int          blk;

		layout_plan = '{LAYOUT_4X4, LAYOUT_4X4, LAYOUT_4X3, LAYOUT_1X4, LAYOUT_UNUSED,
			LAYOUT_4X4, LAYOUT_4X3, LAYOUT_1X4, LAYOUT_4X4, LAYOUT_4X3, LAYOUT_1X4};
		hold_plan = '{32'd0, 32'd5, 32'd20, 32'd3, 32'd10, 32'hFFFF_FFFF, 32'd1000, 32'd0,
			32'($urandom_range(1, 60)), 32'($urandom_range(0, 30)), $urandom};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The hold is timed across the wrap of the millisecond counter.
		t = 32'hFFFF_FF00;
		send_scan(16'h0000, t);
		send_scan(16'h8000, t);
		send_scan(16'hFFFF, t + 1);
		send_scan(16'h8000, t + 1001);
		send_scan(16'h8000, t + 1002);
		send_scan(16'h0000, t + 1003);
		send_scan(16'h0001, t + 1004);
		send_scan(16'h0002, t + 1005);
		send_scan(16'h0000, t + 1006);
		send_scan(16'h0020, t + 1007);
		write_reg(REG_KEYPAD_TYPE, 32'(LAYOUT_UNUSED));
		send_scan(16'hFFFF, 32'd0);
		write_reg(REG_KEYPAD_TYPE, 32'(LAYOUT_1X4));
		send_scan(16'h0001, 32'd1);
		send_scan(16'h0002, 32'd2);
		send_scan(16'h0004, 32'd3);
		send_scan(16'h0008, 32'd4);
		send_scan(16'h000F, 32'd5);
		send_scan(16'hFFF0, 32'd6);
		write_reg(REG_KEYPAD_TYPE, 32'(LAYOUT_4X3));
		send_scan(16'h0008, 32'd7);
		send_scan(16'h4000, 32'd8);
		send_scan(16'h7777, 32'd9);
		send_scan(16'h0001, 32'd10);
		write_reg(REG_KEYPAD_TYPE, 32'(LAYOUT_4X4));
		write_reg(REG_HOLD_TIME_MS, 32'hFFFF_FFFF);
		send_scan(16'h0400, 32'd0);
		send_scan(16'h0400, 32'hFFFF_FFFF);
		write_reg(REG_HOLD_TIME_MS, 32'd0);
		send_scan(16'h0010, 32'd5);
		send_scan(16'h0010, 32'd5);
		send_scan(16'h0010, 32'd6);

		for (blk = 0; blk < 11; blk++) begin
			if (blk == 0) begin
				send_idle_pct = 15;
				recv_idle_pct = 56;
			end else if (blk == 4) begin
				send_idle_pct = 56;
				recv_idle_pct = 15;
			end else if (blk == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(REG_KEYPAD_TYPE, 32'(layout_plan[blk]));
			write_reg(REG_HOLD_TIME_MS, hold_plan[blk]);
			play_random(150);
		end

		drain();
		$display("Sent %0d scan beats with %0d register writes across every layout code,",
			scans_sent, reg_writes);
		$display("hold times from zero to the maximum, under three idling patterns.");
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ keypad_scan_event_detector.f @@
sv/kse_pkg.sv
sv/kse_key_pick.sv
sv/kse_event.sv
sv/keypad_scan_event_detector.sv
bench/kse_event_checker.sv
bench/tb_keypad_scan_event_detector.sv
